### sv/ptw_pkg.sv
package ptw_pkg;

	localparam int VA_W        = 48;
	localparam int DATA_W      = 64;
	localparam int PN_W        = 36;
	localparam int FRAME_W     = 52;
	localparam int IDX_W       = 9;
	localparam int LEVEL_W     = 2;
	localparam int PAGE_SHIFT  = 12;
	localparam int CFG_IDX_W   = 2;
	localparam int IN_TDATA_W  = VA_W + DATA_W;
	localparam int OUT_DATA_W  = DATA_W + FRAME_W + 1;
	localparam int OUT_TDATA_W = ((OUT_DATA_W + 7) / 8) * 8;
	localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_DATA_W;

	localparam logic [CFG_IDX_W-1:0] REG_ROOT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 2'd1;

	localparam logic [LEVEL_W-1:0] LEVEL_LEAF = 2'd3;

	typedef enum logic [1:0] {
		CMD_TRANSLATE = 2'd0,
		CMD_UNMAP     = 2'd1,
		CMD_RESPONSE  = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_READ       = 2'd0,
		KIND_WRITE_ZERO = 2'd1,
		KIND_XLATE_DONE = 2'd2,
		KIND_UNMAP_NONE = 2'd3
	} kind_t;

	// one walk step as held in the input register
	typedef struct packed {
		cmd_t                cmd;
		logic [PN_W-1:0]     page_number;
		logic                present;
		logic [FRAME_W-1:0]  frame;      // entry bits 51:12, low 12 zero
		logic [DATA_W-1:0]   next_base;  // frame + window offset
	} step_in_t;

	typedef struct packed {
		logic                valid;
		kind_t               kind;
		logic [DATA_W-1:0]   mem_address;
		logic [FRAME_W-1:0]  physical_frame;
		logic                mapped;
	} step_res_t;

	// 9-bit table index of a page number at a given level
	function automatic logic [IDX_W-1:0] level_index(input logic [PN_W-1:0] pn,
			input logic [LEVEL_W-1:0] level);
		logic [IDX_W-1:0] idx;
		case (level)
			2'd0:    idx = pn[4*IDX_W-1:3*IDX_W];
			2'd1:    idx = pn[3*IDX_W-1:2*IDX_W];
			2'd2:    idx = pn[2*IDX_W-1:IDX_W];
			default: idx = pn[IDX_W-1:0];
		endcase
		return idx;
	endfunction

endpackage

### sv/ptw_core.sv
module ptw_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       go,
	input  ptw_pkg::step_in_t          step,
	input  logic [ptw_pkg::DATA_W-1:0] root_table_address,
	output ptw_pkg::step_res_t         res
);

	logic                         busy_q;
	logic                         unmap_q;
	logic [ptw_pkg::LEVEL_W-1:0]  level_q;
	logic [ptw_pkg::PN_W-1:0]     pn_q;
	logic [ptw_pkg::DATA_W-1:0]   leaf_q;

	logic                         busy_d;
	logic                         unmap_d;
	logic [ptw_pkg::LEVEL_W-1:0]  level_d;
	logic [ptw_pkg::PN_W-1:0]     pn_d;
	logic [ptw_pkg::DATA_W-1:0]   leaf_d;

	logic [ptw_pkg::DATA_W-1:0]   base;
	logic [ptw_pkg::IDX_W-1:0]    idx;
	logic [ptw_pkg::DATA_W-1:0]   rd_addr;
	logic                         start;

	assign start = (step.cmd == ptw_pkg::CMD_TRANSLATE || step.cmd == ptw_pkg::CMD_UNMAP)
		&& !busy_q;

	// shared entry address adder: start reads the root table, a present
	// non-leaf entry reads the next level
	always_comb begin
		if (start) begin
			base = root_table_address;
			idx  = ptw_pkg::level_index(step.page_number, '0);
		end else begin
			base = step.next_base;
			idx  = ptw_pkg::level_index(pn_q, level_q + 2'd1);
		end
	end

	assign rd_addr = base + {{(ptw_pkg::DATA_W-ptw_pkg::IDX_W-3){1'b0}}, idx, 3'b000};

	always_comb begin
		busy_d  = busy_q;
		unmap_d = unmap_q;
		level_d = level_q;
		pn_d    = pn_q;
		leaf_d  = leaf_q;
		res     = '0;
		case (step.cmd)
			ptw_pkg::CMD_TRANSLATE, ptw_pkg::CMD_UNMAP: begin
				if (start) begin
					busy_d          = 1'b1;
					unmap_d         = (step.cmd == ptw_pkg::CMD_UNMAP);
					level_d         = '0;
					pn_d            = step.page_number;
					leaf_d          = rd_addr;
					res.valid       = 1'b1;
					res.kind        = ptw_pkg::KIND_READ;
					res.mem_address = rd_addr;
				end
			end
			ptw_pkg::CMD_RESPONSE: begin
				if (busy_q) begin
					res.valid = 1'b1;
					if (!step.present) begin
						busy_d   = 1'b0;
						res.kind = unmap_q ? ptw_pkg::KIND_UNMAP_NONE
							: ptw_pkg::KIND_XLATE_DONE;
					end else if (level_q != ptw_pkg::LEVEL_LEAF) begin
						level_d         = level_q + 2'd1;
						leaf_d          = rd_addr;
						res.kind        = ptw_pkg::KIND_READ;
						res.mem_address = rd_addr;
					end else if (unmap_q) begin
						busy_d          = 1'b0;
						res.kind        = ptw_pkg::KIND_WRITE_ZERO;
						res.mem_address = leaf_q;
					end else begin
						busy_d             = 1'b0;
						res.kind           = ptw_pkg::KIND_XLATE_DONE;
						res.physical_frame = step.frame;
						res.mapped         = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			unmap_q <= 1'b0;
			level_q <= '0;
			pn_q    <= '0;
			leaf_q  <= '0;
		end else if (go) begin
			busy_q  <= busy_d;
			unmap_q <= unmap_d;
			level_q <= level_d;
			pn_q    <= pn_d;
			leaf_q  <= leaf_d;
		end
	end

`ifndef SYNTHESIS
	a_wz_at_leaf: assert property (@(posedge clk) disable iff (!arst_n)
		go && res.valid && res.kind == ptw_pkg::KIND_WRITE_ZERO
		|-> busy_q && unmap_q && level_q == ptw_pkg::LEVEL_LEAF)
		else $error("write-zero issued outside an unmap leaf step");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		go && start |=> busy_q && level_q == '0)
		else $error("walk start did not enter level zero");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		go && res.valid && res.kind != ptw_pkg::KIND_READ |=> !busy_q)
		else $error("walk still busy after final result");
	a_read_addr: assert property (@(posedge clk) disable iff (!arst_n)
		go && res.valid && res.kind == ptw_pkg::KIND_READ |=> leaf_q == $past(rd_addr))
		else $error("leaf entry address not tracking last read");
`endif

endmodule

### sv/page_table_walker.sv
// Four-level page table walker.
// Channels: s_* takes requests; s_tuser is the command (translate, unmap,
// or memory read response) and s_tdata carries the virtual address and the
// returned entry. m_* emits one result per request that causes one: a read
// request, a write-zero request, translate done, or unmap found nothing.
// cfg_* writes root_table_address (index 0) and window_offset (index 1);
// it is always ready; it must be written only while no walk is in flight, but
// the block itself does not enforce this. A request passes the input
// register, then the result register, before m_tvalid. One request per
// cycle unless a held result stalls; the walk advances one level per memory
// response, so a full walk takes four read round trips to the memory behind it.
// Ignored requests (start while busy, response while idle, unused command)
// pass the input register and produce nothing.
// Reset clears the walk state, both config registers and the valid flags.
// When m_tready is low, a held result blocks only the next request that
// would produce a result; s_tready drops until the result is taken.
module page_table_walker (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [ptw_pkg::IN_TDATA_W-1:0]       s_tdata,  // virtual_address, read_data
	input  logic [1:0]                           s_tuser,  // cmd
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [ptw_pkg::OUT_TDATA_W-1:0]      m_tdata,  // mem_address, physical_frame,
	                                                       // mapped, zero pad
	output logic [1:0]                           m_tuser,  // kind
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [ptw_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [ptw_pkg::DATA_W-1:0]           cfg_data
);

	logic [ptw_pkg::DATA_W-1:0] root_q;
	logic [ptw_pkg::DATA_W-1:0] window_q;

	logic                       valid_s1;
	ptw_pkg::step_in_t          step_s1;
	ptw_pkg::step_res_t         res;
	logic                       advance;

	logic                       valid_s2;
	ptw_pkg::kind_t             kind_s2;
	logic [ptw_pkg::DATA_W-1:0] addr_s2;
	logic [ptw_pkg::FRAME_W-1:0] frame_s2;
	logic                       mapped_s2;

	logic [ptw_pkg::DATA_W-1:0] in_entry;
	logic [ptw_pkg::FRAME_W-1:0] in_frame;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_q   <= '0;
			window_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				ptw_pkg::REG_ROOT:   root_q   <= cfg_data;
				ptw_pkg::REG_WINDOW: window_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// input register; frame + window offset is formed here so stage 1
	// holds a single address add
	assign in_entry = s_tdata[ptw_pkg::IN_TDATA_W-1:ptw_pkg::VA_W];
	assign in_frame = {in_entry[ptw_pkg::FRAME_W-1:ptw_pkg::PAGE_SHIFT],
		{ptw_pkg::PAGE_SHIFT{1'b0}}};

	assign advance  = valid_s1 && (!res.valid || !valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			step_s1.cmd         <= ptw_pkg::cmd_t'(s_tuser);
			step_s1.page_number <= s_tdata[ptw_pkg::VA_W-1:ptw_pkg::PAGE_SHIFT];
			step_s1.present     <= in_entry[0];
			step_s1.frame       <= in_frame;
			step_s1.next_base   <= {{(ptw_pkg::DATA_W-ptw_pkg::FRAME_W){1'b0}}, in_frame}
				+ window_q;
		end
	end

	ptw_core u_core (
		.clk                (clk),
		.arst_n             (arst_n),
		.go                 (advance),
		.step               (step_s1),
		.root_table_address (root_q),
		.res                (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance && res.valid) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			kind_s2   <= res.kind;
			addr_s2   <= res.mem_address;
			frame_s2  <= res.physical_frame;
			mapped_s2 <= res.mapped;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = kind_s2;
	assign m_tdata  = {{ptw_pkg::OUT_PAD_W{1'b0}}, mapped_s2, frame_s2, addr_s2};

`ifndef SYNTHESIS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !m_tready |=> valid_s2 && $stable(addr_s2) && $stable(kind_s2))
		else $error("held result changed before it was taken");
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && res.valid && valid_s2 && !m_tready |-> !s_tready)
		else $error("input taken while a result had nowhere to go");
	a_mapped_kind: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && mapped_s2 |-> kind_s2 == ptw_pkg::KIND_XLATE_DONE)
		else $error("mapped flag on a non-translate result");
`endif

endmodule
